// ===== rtl/core/ple_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

  localparam int ACTION_W = 3;
  localparam int POS_W    = 7;
  localparam int VAL_W    = 16;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 7;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [VAL_W-1:0]    val_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [LEN_W-1:0]    len_t;

  localparam action_t ACT_INS_FRONT = 3'd0;
  localparam action_t ACT_INS_POS   = 3'd1;
  localparam action_t ACT_INS_END   = 3'd2;
  localparam action_t ACT_REM_FRONT = 3'd3;
  localparam action_t ACT_REM_POS   = 3'd4;
  localparam action_t ACT_REM_END   = 3'd5;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_RANGE = 2'd2;
  localparam status_t ST_FULL  = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/core/ple_cmd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ple_cmd_if;
  logic           valid;
  logic           ready;
  ple_pkg::action_t action;
  ple_pkg::pos_t    position;
  ple_pkg::val_t    element_value;

  modport source (output valid, output action, output position, output element_value,
                  input ready);
  modport sink   (input valid, input action, input position, input element_value,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ple_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ple_rsp_if;
  logic             valid;
  logic             ready;
  ple_pkg::val_t    removed_value;
  ple_pkg::status_t status;
  ple_pkg::len_t    length;

  modport source (output valid, output removed_value, output status, output length,
                  input ready);
  modport sink   (input valid, input removed_value, input status, input length,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/positional_list_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A rejected or unknown request goes straight to the done state, which loads the result
// register once the output register is free. Insert at p shifts entries p to the tail up,
// then writes p; removal reads p, then shifts the entries above it down. One request at a
// time; the memory's single read and write port costs a read and a write state per entry
// moved. A waiting result does not block the next request. Reset (synchronous) clears the
// length and the control state; the entry memory is not cleared and needs no clearing pass.
module positional_list_engine #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  ple_cmd_if.sink   cmd,
  ple_rsp_if.source rsp
);

  localparam int AW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;
  localparam int XW = VALUE_BITS + ple_pkg::VAL_W;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_STEP = 3'd1;
  localparam logic [2:0] S_INS_WR   = 3'd2;
  localparam logic [2:0] S_REM_TAKE = 3'd3;
  localparam logic [2:0] S_REM_STEP = 3'd4;
  localparam logic [2:0] S_REM_WR   = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [VALUE_BITS-1:0] mem [CAPACITY];
  logic [VALUE_BITS-1:0] rd_data;

  logic [2:0]            state, state_next;
  logic [CW-1:0]         count, count_next;
  logic [CW-1:0]         k, k_next;
  logic [CW-1:0]         at, at_next;
  logic [VALUE_BITS-1:0] value, value_next;
  logic [VALUE_BITS-1:0] taken, taken_next;
  ple_pkg::status_t      status, status_next;

  logic                  out_valid;
  ple_pkg::val_t         out_value;
  ple_pkg::status_t      out_status;
  ple_pkg::len_t         out_length;

  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [VALUE_BITS-1:0] wr_data;

  logic [WW-1:0]         pos_w;
  logic [WW-1:0]         cnt_w;
  logic [XW-1:0]         in_ext;
  logic [XW-1:0]         taken_ext;
  logic [WW-1:0]         len_ext;
  logic                  accept;
  logic                  load_out;
  logic                  full;
  logic                  empty;

  assign pos_w     = WW'(cmd.position);
  assign cnt_w     = WW'(count);
  assign in_ext    = XW'(cmd.element_value);
  assign taken_ext = XW'(taken);
  assign len_ext   = WW'(count);
  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);
  assign accept    = cmd.valid && cmd.ready;
  assign load_out  = (state == S_DONE) && (!out_valid || rsp.ready);

  assign cmd.ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    count_next  = count;
    k_next      = k;
    at_next     = at;
    value_next  = value;
    taken_next  = taken;
    status_next = status;
    rd_en       = 1'b0;
    rd_addr     = k[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = k[AW-1:0];
    wr_data     = rd_data;
    case (state)
      S_IDLE: begin
        if (accept) begin
          value_next  = in_ext[VALUE_BITS-1:0];
          taken_next  = '0;
          status_next = ple_pkg::ST_OK;
          state_next  = S_DONE;
          case (cmd.action)
            ple_pkg::ACT_INS_FRONT, ple_pkg::ACT_INS_POS, ple_pkg::ACT_INS_END: begin
              if (full) begin
                status_next = ple_pkg::ST_FULL;
              end else if (cmd.action == ple_pkg::ACT_INS_POS && pos_w > cnt_w) begin
                status_next = ple_pkg::ST_RANGE;
              end else begin
                if (cmd.action == ple_pkg::ACT_INS_FRONT) begin
                  at_next = '0;
                end else if (cmd.action == ple_pkg::ACT_INS_END) begin
                  at_next = count;
                end else begin
                  at_next = pos_w[CW-1:0];
                end
                k_next     = count;
                state_next = S_INS_STEP;
              end
            end
            ple_pkg::ACT_REM_FRONT, ple_pkg::ACT_REM_POS, ple_pkg::ACT_REM_END: begin
              if (empty) begin
                status_next = ple_pkg::ST_EMPTY;
              end else if (cmd.action == ple_pkg::ACT_REM_POS && pos_w >= cnt_w) begin
                status_next = ple_pkg::ST_RANGE;
              end else begin
                if (cmd.action == ple_pkg::ACT_REM_FRONT) begin
                  at_next = '0;
                end else if (cmd.action == ple_pkg::ACT_REM_END) begin
                  at_next = count - 1'b1;
                end else begin
                  at_next = pos_w[CW-1:0];
                end
                rd_en      = 1'b1;
                rd_addr    = at_next[AW-1:0];
                state_next = S_REM_TAKE;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_INS_STEP: begin
        if (k > at) begin
          rd_en      = 1'b1;
          rd_addr    = k_next[AW-1:0] - 1'b1;
          state_next = S_INS_WR;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = at[AW-1:0];
          wr_data    = value;
          count_next = count + 1'b1;
          state_next = S_DONE;
        end
      end
      S_INS_WR: begin
        wr_en      = 1'b1;
        wr_addr    = k[AW-1:0];
        k_next     = k - 1'b1;
        state_next = S_INS_STEP;
      end
      S_REM_TAKE: begin
        taken_next = rd_data;
        k_next     = at;
        state_next = S_REM_STEP;
      end
      S_REM_STEP: begin
        if (k + 1'b1 < count) begin
          rd_en      = 1'b1;
          rd_addr    = k[AW-1:0] + 1'b1;
          state_next = S_REM_WR;
        end else begin
          count_next = count - 1'b1;
          state_next = S_DONE;
        end
      end
      S_REM_WR: begin
        wr_en      = 1'b1;
        wr_addr    = k[AW-1:0];
        k_next     = k + 1'b1;
        state_next = S_REM_STEP;
      end
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k      <= k_next;
    at     <= at_next;
    value  <= value_next;
    taken  <= taken_next;
    status <= status_next;
    if (load_out) begin
      out_value  <= taken_ext[ple_pkg::VAL_W-1:0];
      out_status <= status;
      out_length <= len_ext[ple_pkg::LEN_W-1:0];
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.removed_value = out_value;
  assign rsp.status        = out_status;
  assign rsp.length        = out_length;

endmodule

`default_nettype wire
